>>> hdl/mbr_pkg.sv
package mbr_pkg;

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 6;
   localparam int VALUE_W  = 16;
   localparam int RESULT_W = 38;
   localparam int DIM_W    = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD_A    = 2'd0,
      ACT_LOAD_B    = 2'd1,
      ACT_LOAD_BIAS = 2'd2,
      ACT_COMPUTE   = 2'd3
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_M      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_K     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_N      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ENABLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0]       action;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic signed [VALUE_W-1:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] result_value;
      logic [INDEX_W-1:0]         out_row;
      logic [INDEX_W-1:0]         out_col;
      logic                       last;
   } rsp_type;

   // control for one step of the column sweep
   typedef struct packed {
      logic                   valid;
      logic                   first;
      logic                   fin;
      logic [INDEX_W-1:0]     col;
      logic                   last;
   } mac_ctl_type;

endpackage

>>> hdl/matmul_bias_relu_engine.sv
// Fused dense layer C = relu(A x B + bias) on signed Q8.8 elements.
// Input channel: req_word is taken when req_start is high and req_busy low.
// Actions load one element of A, B or the bias vector (no result) or
// compute one output row. A compute emits cols_n words (0 reads as 1,
// capped at MAX_COLS) on rsp_strobe/rsp_word, one column at a time in
// increasing order, with last on the final column; each word is present
// for one cycle only. A compute sweeps N*K steps, one product per step,
// through the memory read, product and output registers; the single
// multiplier and the one-read-per-cycle ports of the A and B memories set
// this pace. busy stays high until the last word has left. The receiver
// cannot stall; words are never held.
// Configuration: csr_write_enable/csr_index/csr_data write rows_m,
// inner_k, cols_n, bias_enable, relu_enable; write only while idle.
// Reset restores the register defaults; memories are left unwritten and
// need no clearing pass. A compute of a row at or beyond rows_m (0 reads
// as 1) yields nothing.
module matmul_bias_relu_engine #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_INNER = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_start,
   output logic                             req_busy,
   input  mbr_pkg::req_type                 req_word,
   output logic                             rsp_strobe,
   output mbr_pkg::rsp_type                 rsp_word,
   input  logic                             csr_write_enable,
   input  logic [mbr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbr_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mbr_pkg::*;

   localparam int RW = (MAX_ROWS  > 1) ? $clog2(MAX_ROWS)  : 1;
   localparam int CW = (MAX_COLS  > 1) ? $clog2(MAX_COLS)  : 1;
   localparam int KW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
   localparam int AAW = (MAX_ROWS * MAX_INNER > 1) ? $clog2(MAX_ROWS * MAX_INNER) : 1;
   localparam int BAW = (MAX_INNER * MAX_COLS > 1) ? $clog2(MAX_INNER * MAX_COLS) : 1;

   logic [DIM_W-1:0] rows_m_ff, inner_k_ff, cols_n_ff;
   logic             bias_en_ff, relu_en_ff;

   // memories
   logic [VALUE_W-1:0] a_mem [MAX_ROWS*MAX_INNER];
   logic [VALUE_W-1:0] b_mem [MAX_INNER*MAX_COLS];
   logic [VALUE_W-1:0] bias_mem [MAX_COLS];
   logic [VALUE_W-1:0] a_rd_ff, b_rd_ff, bias_rd_ff;

   typedef enum logic {IDLE, RUN} state_type;
   state_type state_ff;
   logic [KW:0] k_ff;
   logic [CW:0] j_ff;
   logic [INDEX_W-1:0] row_ff;
   logic [8:0] m_eff, k_eff, n_eff;
   mac_ctl_type ctl_ff, ctl_in;

   function automatic logic [8:0] eff(input logic [DIM_W-1:0] v, input int mx);
      logic [8:0] r;
      r = (v == '0) ? 9'd1 : ({2'b0, v} > 9'(mx)) ? 9'(mx) : {2'b0, v};
      return r;
   endfunction

   assign m_eff = eff(rows_m_ff, MAX_ROWS);
   assign k_eff = eff(inner_k_ff, MAX_INNER);
   assign n_eff = eff(cols_n_ff, MAX_COLS);

   logic accept;
   assign accept = req_start && !req_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m_ff <= 7'd64; inner_k_ff <= 7'd64; cols_n_ff <= 7'd64;
         bias_en_ff <= 1'b0; relu_en_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ROWS_M:      rows_m_ff  <= csr_data;
            CSR_INNER_K:     inner_k_ff <= csr_data;
            CSR_COLS_N:      cols_n_ff  <= csr_data;
            CSR_BIAS_ENABLE: bias_en_ff <= csr_data[0];
            CSR_RELU_ENABLE: relu_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // write loads; drop out-of-range indices
   always_ff @(posedge clock) begin
      if (accept && req_word.action == ACT_LOAD_A &&
          32'(req_word.row_index) < MAX_ROWS && 32'(req_word.col_index) < MAX_INNER)
         a_mem[AAW'(RW'(req_word.row_index) * MAX_INNER + KW'(req_word.col_index))] <=
            req_word.load_value;
      if (accept && req_word.action == ACT_LOAD_B &&
          32'(req_word.row_index) < MAX_INNER && 32'(req_word.col_index) < MAX_COLS)
         b_mem[BAW'(KW'(req_word.row_index) * MAX_COLS + CW'(req_word.col_index))] <=
            req_word.load_value;
      if (accept && req_word.action == ACT_LOAD_BIAS &&
          32'(req_word.col_index) < MAX_COLS)
         bias_mem[CW'(req_word.col_index)] <= req_word.load_value;
      a_rd_ff    <= a_mem[AAW'(RW'(row_ff) * MAX_INNER + KW'(k_ff[KW-1:0]))];
      b_rd_ff    <= b_mem[BAW'(KW'(k_ff[KW-1:0]) * MAX_COLS + CW'(j_ff[CW-1:0]))];
      bias_rd_ff <= bias_mem[CW'(j_ff[CW-1:0])];
   end

   // sweep: columns outer, inner index inner
   always_comb begin
      ctl_in = '0;
      if (state_ff == RUN) begin
         ctl_in.valid = 1'b1;
         ctl_in.first = (k_ff == '0);
         ctl_in.fin   = (9'(k_ff) + 9'd1 == k_eff);
         ctl_in.col   = INDEX_W'(j_ff);
         ctl_in.last  = ctl_in.fin && (9'(j_ff) + 9'd1 == n_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE; k_ff <= '0; j_ff <= '0; ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
         case (state_ff)
            IDLE: if (accept && req_word.action == ACT_COMPUTE &&
                      {3'b0, req_word.row_index} < m_eff) begin
               state_ff <= RUN; row_ff <= req_word.row_index;
               k_ff <= '0; j_ff <= '0;
            end
            RUN: begin
               if (ctl_in.fin) begin
                  k_ff <= '0; j_ff <= j_ff + 1'b1;
                  if (ctl_in.last) state_ff <= IDLE;
               end else k_ff <= k_ff + 1'b1;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // busy covers the sweep and the pipeline drain
   mac_ctl_type ctl2_ff;
   logic drain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin ctl2_ff <= '0; drain_ff <= 1'b0; end
      else begin ctl2_ff <= ctl_ff; drain_ff <= ctl2_ff.valid; end
   end
   assign req_busy = (state_ff == RUN) || ctl_ff.valid || ctl2_ff.valid || drain_ff;

   mbr_mac #(.INNER_W(KW)) u_mac (
      .clock(clock), .reset(reset), .ctl(ctl_ff),
      .a_val(a_rd_ff), .b_val(b_rd_ff), .bias_val(bias_rd_ff),
      .bias_on(bias_en_ff), .relu_on(relu_en_ff), .row(row_ff),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> req_busy) else $error("run not busy");
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> 9'(k_ff) < k_eff) else $error("k overrun");
   a_j_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == RUN |-> 9'(j_ff) < n_eff) else $error("j overrun");
endmodule

>>> hdl/mbr_mac.sv
// Multiply-accumulate and output stage: product register, accumulator,
// bias add, clamp and ReLU.
module mbr_mac #(
   parameter int INNER_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mbr_pkg::mac_ctl_type          ctl,
   input  logic signed [15:0]            a_val,
   input  logic signed [15:0]            b_val,
   input  logic signed [15:0]            bias_val,
   input  logic                          bias_on,
   input  logic                          relu_on,
   input  logic [5:0]                    row,
   output logic                          rsp_strobe,
   output mbr_pkg::rsp_type              rsp_word
);
   import mbr_pkg::*;

   localparam int ACC_W = 32 + INNER_W + 1;

   logic signed [31:0]      prod_ff;
   logic signed [15:0]      bias_ff;
   mac_ctl_type             pctl_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] sum;
   logic signed [RESULT_W-1:0] res;
   logic                    strobe_ff;
   rsp_type                 word_ff;

   // hold the bias of the same sweep step as the product
   always_ff @(posedge clock) begin
      prod_ff <= a_val * b_val;
      bias_ff <= bias_val;
      if (reset) pctl_ff <= '0;
      else pctl_ff <= ctl;
   end

   always_comb begin
      acc_in = pctl_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
      sum = acc_in;
      if (bias_on) sum = acc_in + ACC_W'(signed'({bias_ff, 8'd0}));
      if (ACC_W > RESULT_W && sum > ACC_W'(signed'({1'b0, {(RESULT_W-1){1'b1}}})))
         res = {1'b0, {(RESULT_W-1){1'b1}}};
      else if (ACC_W > RESULT_W && sum < -ACC_W'(signed'({1'b0, {(RESULT_W-1){1'b1}}})) - 1)
         res = {1'b1, {(RESULT_W-1){1'b0}}};
      else
         res = RESULT_W'(sum);
      if (relu_on && res < 0) res = '0;
   end

   always_ff @(posedge clock) begin
      if (pctl_ff.valid) acc_ff <= acc_in;
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= pctl_ff.valid && pctl_ff.fin;
      word_ff.result_value <= res;
      word_ff.out_row <= row;
      word_ff.out_col <= pctl_ff.col;
      word_ff.last <= pctl_ff.last;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word = word_ff;

   a_last_needs_fin: assert property (@(posedge clock) disable iff (reset)
      pctl_ff.valid && pctl_ff.last |-> pctl_ff.fin) else $error("last without fin");
   a_strobe_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(pctl_ff.valid)) else $error("stray strobe");
   a_relu: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(relu_on) |-> !rsp_word.result_value[RESULT_W-1])
      else $error("relu broke");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import mbr_pkg::*;

   localparam int ROWS  = 64;
   localparam int COLS  = 64;
   localparam int INNER = 64;
   localparam int RANDOM_WORDS = 50;
   localparam longint CYCLE_LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic req_busy;
   req_type req_word = '0;
   logic rsp_strobe;
   rsp_type rsp_word;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   matmul_bias_relu_engine u_top (
      .clock(clock), .reset(reset),
      .req_start(req_start), .req_busy(req_busy), .req_word(req_word),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the engine: matrices, bias and dimension registers
   logic signed [15:0] a_mat [ROWS][INNER];
   logic signed [15:0] b_mat [INNER][COLS];
   logic signed [15:0] bias_vec [COLS];
   logic [6:0] rows_m, inner_k, cols_n;
   logic bias_on, relu_on;

   rsp_type pending_words [$];
   int error_count = 0;
   longint cycle_count = 0;

   task automatic report(input string what, input longint got, input longint want);
      $display("ERROR @%0t: %s got %0d want %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int clamp_dim(input logic [6:0] v, input int top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // exact dot product of one row of A against column j of B, bias aligned, ReLU applied
   function automatic logic signed [37:0] dense_sum(input int row, input int col);
      longint acc;
      acc = 0;
      for (int t = 0; t < clamp_dim(inner_k, INNER); t++)
         acc += longint'(a_mat[row][t]) * longint'(b_mat[t][col]);
      if (bias_on) acc += longint'(bias_vec[col]) * 256;
      if (relu_on && acc < 0) acc = 0;
      return acc[37:0];
   endfunction

   // apply one word to the shadow and queue what it yields
   task automatic predict_word(input req_type w);
      rsp_type r;
      int m, n;
      case (action_type'(w.action))
         ACT_LOAD_A: begin
            a_mat[w.row_index][w.col_index] = w.load_value;
         end
         ACT_LOAD_B: begin
            b_mat[w.row_index][w.col_index] = w.load_value;
         end
         ACT_LOAD_BIAS: begin
            bias_vec[w.col_index] = w.load_value;
         end
         ACT_COMPUTE: begin
            m = clamp_dim(rows_m, ROWS);
            n = clamp_dim(cols_n, COLS);
            if (w.row_index < m) begin
               for (int j = 0; j < n; j++) begin
                  r.result_value = dense_sum(w.row_index, j);
                  r.out_row = w.row_index;
                  r.out_col = INDEX_W'(j);
                  r.last = (j == n - 1);
                  pending_words.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endtask

   // sample results at the rising edge; compare with and drop the oldest expectation
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            report("unexpected word, col", rsp_word.out_col, -1);
         end else begin
            rsp_type want;
            want = pending_words.pop_front();
            if (rsp_word.result_value !== want.result_value)
               report("result_value", rsp_word.result_value, want.result_value);
            if (rsp_word.out_row !== want.out_row)
               report("out_row", rsp_word.out_row, want.out_row);
            if (rsp_word.out_col !== want.out_col)
               report("out_col", rsp_word.out_col, want.out_col);
            if (rsp_word.last !== want.last)
               report("last", rsp_word.last, want.last);
         end
      end
   end

   // hold start until the word is accepted; keep it high into the next word
   // when there is no gap, drop it for the gap otherwise
   task automatic send_word(input req_type w, input bit use_gap = 1);
      int gap;
      gap = use_gap ? $urandom_range(0, 4) : 0;
      if ($urandom_range(0, 9) < 3) gap = 0;
      if (gap != 0) begin
         req_start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_word <= w;
      req_start <= 1'b1;
      do @(posedge clock); while (req_busy);
      predict_word(w);
      @(negedge clock);
   endtask

   // drain every expected word, then let the sweep tail settle
   task automatic settle();
      req_start <= 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
      while (req_busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_ROWS_M:      rows_m = 7'(val);
         CSR_INNER_K:     inner_k = 7'(val);
         CSR_COLS_N:      cols_n = 7'(val);
         CSR_BIAS_ENABLE: bias_on = val[0];
         CSR_RELU_ENABLE: relu_on = val[0];
         default: ;
      endcase
   endtask

   function automatic req_type make_word(input action_type act, input int row,
                                         input int col, input int val);
      req_type w;
      w.action = act;
      w.row_index = INDEX_W'(row);
      w.col_index = INDEX_W'(col);
      w.load_value = VALUE_W'(val);
      return w;
   endfunction

   // fill everything a compute under the given shape reads
   task automatic fill_region(input int m, input int k, input int n, input bit wild);
      for (int r = 0; r < m; r++)
         for (int t = 0; t < k; t++)
            send_word(make_word(ACT_LOAD_A, r, t,
               wild ? $urandom : $urandom_range(0, 1023) - 512), 0);
      for (int t = 0; t < k; t++)
         for (int c = 0; c < n; c++)
            send_word(make_word(ACT_LOAD_B, t, c,
               wild ? $urandom : $urandom_range(0, 1023) - 512), 0);
      for (int c = 0; c < n; c++)
         send_word(make_word(ACT_LOAD_BIAS, $urandom, c, $urandom), 0);
   endtask

   typedef struct {
      req_type w;
      bit check_value;
      logic signed [37:0] value;
   } stim_row_type;

   stim_row_type directed [17];

   initial begin
      int sent;
      int m, k, n;
      rows_m = 64; inner_k = 64; cols_n = 64; bias_on = 0; relu_on = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // tiny 2x2x2 shape, values chosen so sums are readable
      write_reg(CSR_ROWS_M, 2);
      write_reg(CSR_INNER_K, 2);
      write_reg(CSR_COLS_N, 2);
      write_reg(CSR_BIAS_ENABLE, 1);
      write_reg(CSR_RELU_ENABLE, 0);
      // row 0, column 0: 2 * 32767 * -32768 plus bias 32767 << 8
      // row 1, column 0: 2 * 2^30 plus bias 32767 << 8
      directed = '{
         '{make_word(ACT_LOAD_A, 0, 0, 16'sh7FFF), 0, 0},
         '{make_word(ACT_LOAD_A, 0, 1, 16'sh7FFF), 0, 0},
         '{make_word(ACT_LOAD_A, 1, 0, -32768), 0, 0},
         '{make_word(ACT_LOAD_A, 1, 1, -32768), 0, 0},
         '{make_word(ACT_LOAD_B, 0, 0, -32768), 0, 0},
         '{make_word(ACT_LOAD_B, 1, 0, -32768), 0, 0},
         '{make_word(ACT_LOAD_B, 0, 1, 256), 0, 0},
         '{make_word(ACT_LOAD_B, 1, 1, 0), 0, 0},
         '{make_word(ACT_LOAD_BIAS, 63, 0, 16'sh7FFF), 0, 0},
         '{make_word(ACT_LOAD_BIAS, 0, 1, -32768), 0, 0},
         '{make_word(ACT_LOAD_A, 63, 63, 16'h5A5A), 0, 0},
         '{make_word(ACT_LOAD_B, 63, 63, 16'hA5A5), 0, 0},
         '{make_word(ACT_LOAD_BIAS, 0, 63, 1), 0, 0},
         '{make_word(ACT_COMPUTE, 0, 63, 16'hFFFF), 1, -38'sd2139029760},
         '{make_word(ACT_COMPUTE, 1, 0, 0), 1, 38'sd2155872000},
         '{make_word(ACT_COMPUTE, 2, 0, 0), 0, 0},
         '{make_word(ACT_COMPUTE, 63, 0, 0), 0, 0}
      };
      foreach (directed[i]) begin
         send_word(directed[i].w);
         if (directed[i].check_value && pending_words.size() != 0 &&
             pending_words[0].result_value !== directed[i].value)
            report("directed prediction", pending_words[0].result_value,
                   directed[i].value);
      end
      settle();

      // full extreme inner size once, then sweep settings
      sent = 0;
      for (int phase = 0; sent < RANDOM_WORDS; phase++) begin
         case (phase % 4)
            0: begin m = 1; k = 1; n = 1; end
            1: begin m = $urandom_range(1, 4); k = $urandom_range(1, 6); n = $urandom_range(1, 6); end
            2: begin
               m = (phase == 2) ? 1 : 2;
               k = (phase == 2) ? 64 : $urandom_range(1, 8);
               n = (phase == 2) ? 1 : 3;
            end
            default: begin m = $urandom_range(1, 3); k = $urandom_range(2, 5); n = $urandom_range(1, 4); end
         endcase
         settle();
         write_reg(CSR_ROWS_M, (phase == 4) ? 0 : m);
         if (phase == 4) m = 1;
         write_reg(CSR_INNER_K, k);
         write_reg(CSR_COLS_N, n);
         write_reg(CSR_BIAS_ENABLE, $urandom_range(0, 1));
         write_reg(CSR_RELU_ENABLE, $urandom_range(0, 1));
         fill_region(m, k, n, phase % 3 == 0);
         for (int i = 0; i < 10 && sent < RANDOM_WORDS; i++) begin
            int pick;
            pick = $urandom_range(0, 9);
            if (pick < 6)
               send_word(make_word(ACT_COMPUTE, $urandom_range(0, m - 1), $urandom, $urandom));
            else if (pick < 7)
               send_word(make_word(ACT_COMPUTE, $urandom_range(m, 63), $urandom, $urandom));
            else if (pick < 8)
               send_word(make_word(ACT_LOAD_A, $urandom_range(0, m - 1),
                                   $urandom_range(0, k - 1), $urandom));
            else if (pick < 9)
               send_word(make_word(ACT_LOAD_B, $urandom_range(0, k - 1),
                                   $urandom_range(0, n - 1), $urandom));
            else
               send_word(make_word(ACT_LOAD_BIAS, $urandom, $urandom_range(0, n - 1),
                                   $urandom));
            sent++;
         end
         // after phase 3, pause until the engine has emptied
         if (phase == 3) settle();
      end

      // extreme rows and columns, inner size 1, reset bias/ReLU settings; run once more
      settle();
      write_reg(CSR_ROWS_M, 127);
      write_reg(CSR_INNER_K, 1);
      write_reg(CSR_COLS_N, 127);
      write_reg(CSR_BIAS_ENABLE, 0);
      write_reg(CSR_RELU_ENABLE, 1);
      fill_region(1, 1, 64, 1);
      send_word(make_word(ACT_COMPUTE, 0, 0, 0));
      settle();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
